// File: sv/stgr_pkg.sv
package stgr_pkg;

  // Printable range of the font
  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] LAST_CODE  = 8'd126;
  localparam int         NUM_GLYPHS = 95;

  // Column index of the blank spacer column after the five font columns
  localparam logic [2:0] BLANK_COL = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

  // One glyph per entry: five column bytes, first column in the top byte,
  // bit 0 of each byte is the top pixel row.
  localparam logic [39:0] FONT_ROM [NUM_GLYPHS] = '{
    40'h0000000000, 40'h00004F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552240, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h020151093E,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149493A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4070403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F44444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4020403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h0C041C1018
  };

  // Scale 0 acts as 1
  function automatic logic [1:0] eff_scale(input logic [1:0] s);
    eff_scale = (s == 2'd0) ? 2'd1 : s;
  endfunction

  // Glyph cell width: 6 columns times scale
  function automatic logic [4:0] cell_width(input logic [1:0] s);
    logic [4:0] w;
    case (s)
      2'd2:    w = 5'd12;
      2'd3:    w = 5'd18;
      default: w = 5'd6;
    endcase
    cell_width = w;
  endfunction

  // v / s for v <= 23 and s in 1..3; divide by 3 as (v*11) >> 5
  function automatic logic [4:0] div_scale(input logic [4:0] v, input logic [1:0] s);
    logic [9:0] prod;
    logic [4:0] q;
    prod = 10'(v) * 10'd11;
    case (s)
      2'd2:    q = v >> 1;
      2'd3:    q = prod[9:5];
      default: q = v;
    endcase
    div_scale = q;
  endfunction

  // Column byte of one glyph column, blank column gives zero
  function automatic logic [7:0] glyph_col(input logic [39:0] g, input logic [2:0] fc);
    logic [7:0] c;
    case (fc)
      3'd0:    c = g[39:32];
      3'd1:    c = g[31:24];
      3'd2:    c = g[23:16];
      3'd3:    c = g[15:8];
      3'd4:    c = g[7:0];
      default: c = 8'h00;
    endcase
    glyph_col = c;
  endfunction

  // Vertically stretched byte of a source column for one page band
  function automatic logic [7:0] band_byte(input logic [7:0] src, input logic [1:0] band,
                                           input logic [1:0] s);
    logic [7:0] b;
    logic [4:0] row;
    b = 8'h00;
    for (int y = 0; y < 8; y++) begin
      row = div_scale({band, 3'(y)}, s);
      if (row < 5'd8 && src[row[2:0]]) begin
        b[y] = 1'b1;
      end
    end
    band_byte = b;
  endfunction

endpackage

// File: sv/stgr_ifs.sv
interface stgr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       start_new;
  logic [2:0] start_page;
  logic [6:0] start_col;

  modport source (output valid, char_code, start_new, start_page, start_col, input ready);
  modport sink   (input valid, char_code, start_new, start_page, start_col, output ready);
endinterface

interface stgr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic [2:0] page_addr;
  logic [6:0] column_addr;
  logic       last;

  modport source (output valid, pixel_byte, page_addr, column_addr, last, input ready);
  modport sink   (input valid, pixel_byte, page_addr, column_addr, last, output ready);
endinterface

interface stgr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] scale;

  modport source (output valid, scale, input ready);
  modport sink   (input valid, scale, output ready);
endinterface

// File: sv/scaled_text_glyph_renderer.sv
// Channel | dir | payload                                         | request
// --------+-----+-------------------------------------------------+--------------------
// chars   | in  | char_code, start_new, start_page, start_col     | one character
// bytes   | out | pixel_byte, page_addr, column_addr, last        | one display column byte
// cfg     | in  | scale                                           | scale register write
//
// A character is taken in IDLE, its cursor placed in CHECK, then EMIT sends 6*s*bands
// bytes (s = scale, bands = visible page bands, up to s), one byte per cycle unless
// bytes stalls, from the shared band/row scaling unit. Dropped characters skip EMIT.
// Reset (rst, synchronous) homes the cursor to page 0 column 0, clears the stop
// flag and sets scale to 1. A stall on bytes holds the byte sequencer; chars
// stays not ready until the character's last byte has been loaded.
module scaled_text_glyph_renderer #(
  parameter int SCREEN_COLS  = 128,
  parameter int SCREEN_PAGES = 8
) (
  input  logic             clk,
  input  logic             rst,
  stgr_in_if.sink          chars,
  stgr_out_if.source       bytes,
  stgr_cfg_if.sink         cfg
);

  // Cursor column can hold a start column of 127 or the right edge itself
  localparam int COL_MAX  = (SCREEN_COLS > 127) ? SCREEN_COLS : 127;
  localparam int COL_W    = $clog2(COL_MAX + 1);
  // Page can be a start page of 7, or the last page, pushed down by up to 3
  localparam int PG_LIM   = (SCREEN_PAGES - 1 > 7) ? SCREEN_PAGES - 1 : 7;
  localparam int PG_W     = $clog2(PG_LIM + 4);

  stgr_pkg::state_t state;

  // Cursor and mode state
  logic [COL_W-1:0] cursor_col;
  logic [PG_W-1:0]  cursor_page;
  logic             stopped;
  logic [1:0]       scale;

  // Per-character latches and sequencer counters
  logic [6:0] glyph_idx;
  logic [1:0] bands;
  logic [1:0] band;
  logic [2:0] fcol;
  logic [1:0] rep;
  logic [2:0] band_page;
  logic [6:0] base_col;
  logic [6:0] cur_col;

  // Output register
  logic       out_valid;
  logic [7:0] pix_q;
  logic [2:0] page_q;
  logic [6:0] col_q;
  logic       last_q;

  logic [1:0] s;
  logic [4:0] width;
  logic       take_char;
  logic       adv;
  logic       last_byte;
  logic       printable;

  // Cursor placement (CHECK state)
  logic               wrap;
  logic [PG_W-1:0]    page1;
  logic [COL_W-1:0]   col1;
  logic               on_screen;
  logic [PG_W:0]      rem_pages;
  logic [1:0]         bands_calc;

  assign s         = stgr_pkg::eff_scale(scale);
  assign width     = stgr_pkg::cell_width(s);

  assign chars.ready = (state == stgr_pkg::ST_IDLE);
  assign take_char   = chars.valid && chars.ready;
  assign printable   = (chars.char_code >= stgr_pkg::FIRST_CODE) &&
                       (chars.char_code <= stgr_pkg::LAST_CODE);

  assign cfg.ready = 1'b1;

  // Wrap when the cell would run past the right edge
  assign wrap = ({1'b0, cursor_col} + (COL_W+1)'(width)) > (COL_W+1)'(SCREEN_COLS);
  assign page1 = wrap ? cursor_page + PG_W'(s) : cursor_page;
  assign col1  = wrap ? '0 : cursor_col;
  assign on_screen = {1'b0, page1} < (PG_W+1)'(SCREEN_PAGES);
  assign rem_pages = (PG_W+1)'(SCREEN_PAGES) - {1'b0, page1};
  // Bottom clip: only the bands still on the display
  assign bands_calc = (rem_pages < (PG_W+1)'(s)) ? rem_pages[1:0] : s;

  // Byte sequencer steps when the output register is free or being drained
  assign adv       = (state == stgr_pkg::ST_EMIT) && (!out_valid || bytes.ready);
  assign last_byte = (band == bands - 2'd1) && (fcol == stgr_pkg::BLANK_COL) &&
                     (rep == s - 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= stgr_pkg::ST_IDLE;
      cursor_col  <= '0;
      cursor_page <= '0;
      stopped     <= 1'b0;
      scale       <= 2'd1;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        scale <= cfg.scale;
      end

      if (adv) begin
        out_valid <= 1'b1;
      end else if (bytes.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        stgr_pkg::ST_IDLE: begin
          if (take_char) begin
            // Start flag reloads the cursor before the character is placed
            if (chars.start_new) begin
              cursor_page <= PG_W'(chars.start_page);
              cursor_col  <= COL_W'(chars.start_col);
              stopped     <= 1'b0;
            end
            state <= stgr_pkg::ST_CHECK;
          end
        end
        stgr_pkg::ST_CHECK: begin
          if (stopped) begin
            state <= stgr_pkg::ST_IDLE;
          end else begin
            cursor_page <= page1;
            if (wrap && !on_screen) begin
              // Wrapped off the bottom: drop until the next start
              cursor_col <= '0;
              stopped    <= 1'b1;
              state      <= stgr_pkg::ST_IDLE;
            end else begin
              cursor_col <= col1 + COL_W'(width);
              state      <= on_screen ? stgr_pkg::ST_EMIT : stgr_pkg::ST_IDLE;
            end
          end
        end
        stgr_pkg::ST_EMIT: begin
          if (adv && last_byte) begin
            state <= stgr_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= stgr_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Payload and counters, no reset needed
  always_ff @(posedge clk) begin
    if (take_char) begin
      glyph_idx <= printable ? 7'(chars.char_code - stgr_pkg::FIRST_CODE) : 7'd0;
    end

    if (state == stgr_pkg::ST_CHECK) begin
      bands     <= bands_calc;
      band      <= 2'd0;
      fcol      <= 3'd0;
      rep       <= 2'd0;
      band_page <= page1[2:0];
      base_col  <= col1[6:0];
      cur_col   <= col1[6:0];
    end

    if (adv) begin
      pix_q  <= stgr_pkg::band_byte(
                  stgr_pkg::glyph_col(stgr_pkg::FONT_ROM[glyph_idx], fcol), band, s);
      page_q <= band_page;
      col_q  <= cur_col;
      last_q <= last_byte;

      // Horizontal repeat, then font column, then page band
      if (rep == s - 2'd1) begin
        rep <= 2'd0;
        if (fcol == stgr_pkg::BLANK_COL) begin
          fcol      <= 3'd0;
          band      <= band + 2'd1;
          band_page <= band_page + 3'd1;
          cur_col   <= base_col;
        end else begin
          fcol    <= fcol + 3'd1;
          cur_col <= cur_col + 7'd1;
        end
      end else begin
        rep     <= rep + 2'd1;
        cur_col <= cur_col + 7'd1;
      end
    end
  end

  assign bytes.valid       = out_valid;
  assign bytes.pixel_byte  = pix_q;
  assign bytes.page_addr   = page_q;
  assign bytes.column_addr = col_q;
  assign bytes.last        = last_q;

endmodule
